### hdl/tlvts_pkg.sv
package tlvts_pkg;

  localparam int unsigned POS_W     = 16;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned HDR_BYTES = 6;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [POS_W-1:0] POS_MAX    = '1;
  localparam logic [CNT_W-1:0] HDR_LAST   = CNT_W'(HDR_BYTES - 1);
  localparam logic [POS_W-1:0] HDR_BACK   = POS_W'(HDR_BYTES - 1);
  localparam int unsigned      HDR_KEEP_W = 8 * (HDR_BYTES - 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_TAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_BIG_END  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_WIDTH = 2'd3;

  typedef enum logic [1:0] {
    WIDTH_U32 = 2'd0,
    WIDTH_U16 = 2'd1,
    WIDTH_U8  = 2'd2
  } width_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_HEADER = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0] search_tag;
    logic [POS_W-1:0] start_offset;
    logic             header_big_endian;
    logic [1:0]       result_width;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] match_offset;
    logic [LEN_W-1:0] value_length;
    logic [VAL_W-1:0] value;
  } result_t;

  function automatic logic length_ok(input logic [1:0] width, input logic [LEN_W-1:0] len);
    logic ok;
    case (width)
      WIDTH_U32: ok = (len == LEN_W'(4)) || (len == LEN_W'(2)) || (len == LEN_W'(1));
      WIDTH_U16: ok = (len == LEN_W'(2)) || (len == LEN_W'(1));
      default:   ok = (len == LEN_W'(1));
    endcase
    return ok;
  endfunction

endpackage

### hdl/tlvts_core.sv
module tlvts_core (
  input  logic                clk,
  input  logic                rst,
  input  tlvts_pkg::cfg_t     cfg,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output tlvts_pkg::result_t  result
);

  logic [tlvts_pkg::POS_W-1:0]      pos, pos_next;
  tlvts_pkg::phase_t                phase, phase_next, ph;
  logic [tlvts_pkg::CNT_W-1:0]      hcount, hcount_next;
  logic [tlvts_pkg::HDR_KEEP_W-1:0] hshift, hshift_next;
  logic [tlvts_pkg::LEN_W-1:0]      remaining, remaining_next;
  logic                             found, found_next;
  logic [tlvts_pkg::POS_W-1:0]      mpos, mpos_next;
  logic [tlvts_pkg::LEN_W-1:0]      mlen, mlen_next;
  logic [tlvts_pkg::VAL_W-1:0]      acc, acc_next;

  logic [8*tlvts_pkg::HDR_BYTES-1:0] hfull;
  logic [tlvts_pkg::TAG_W-1:0]       tag;
  logic [tlvts_pkg::LEN_W-1:0]       len;
  logic [tlvts_pkg::LEN_W-1:0]       rem_dec;

  assign hfull   = {hshift, data_byte};
  assign tag     = cfg.header_big_endian ? hfull[47:16]
                 : {hfull[23:16], hfull[31:24], hfull[39:32], hfull[47:40]};
  assign len     = cfg.header_big_endian ? hfull[15:0] : {hfull[7:0], hfull[15:8]};
  assign rem_dec = remaining - tlvts_pkg::LEN_W'(1);

  always_comb begin
    pos_next       = pos;
    phase_next     = phase;
    hcount_next    = hcount;
    hshift_next    = hshift;
    remaining_next = remaining;
    found_next     = found;
    mpos_next      = mpos;
    mlen_next      = mlen;
    acc_next       = acc;
    ph             = phase;
    result         = '0;

    if (step) begin
      // bytes at the saturated position are dropped
      if (pos != tlvts_pkg::POS_MAX) begin
        if (phase == tlvts_pkg::PH_SKIP && pos == cfg.start_offset) begin
          ph = tlvts_pkg::PH_HEADER;
        end
        phase_next = ph;
        pos_next   = pos + tlvts_pkg::POS_W'(1);
        case (ph)
          tlvts_pkg::PH_HEADER: begin
            if (hcount == tlvts_pkg::HDR_LAST) begin
              hcount_next    = '0;
              hshift_next    = '0;
              remaining_next = len;
              if (tag == cfg.search_tag) begin
                found_next = 1'b1;
                mpos_next  = pos - tlvts_pkg::HDR_BACK;
                mlen_next  = len;
                acc_next   = '0;
                phase_next = (len == '0) ? tlvts_pkg::PH_DONE : tlvts_pkg::PH_VALUE;
              end else begin
                phase_next = (len == '0) ? tlvts_pkg::PH_HEADER : tlvts_pkg::PH_VALUE;
              end
            end else begin
              hshift_next = hfull[tlvts_pkg::HDR_KEEP_W-1:0];
              hcount_next = hcount + tlvts_pkg::CNT_W'(1);
            end
          end
          tlvts_pkg::PH_VALUE: begin
            if (found && mlen <= tlvts_pkg::LEN_W'(4)) begin
              acc_next = {acc[tlvts_pkg::VAL_W-9:0], data_byte};
            end
            remaining_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = found ? tlvts_pkg::PH_DONE : tlvts_pkg::PH_HEADER;
            end
          end
          default: ;
        endcase
      end

      if (last_byte) begin
        if (found_next) begin
          result.match_offset = mpos_next;
          result.value_length = mlen_next;
          if (!tlvts_pkg::length_ok(cfg.result_width, mlen_next)) begin
            result.status = tlvts_pkg::ST_BAD_LEN;
          end else if (phase_next != tlvts_pkg::PH_DONE) begin
            result.status = tlvts_pkg::ST_TRUNC;
          end else begin
            result.status = tlvts_pkg::ST_FOUND;
            result.value  = acc_next;
          end
        end else if (phase_next == tlvts_pkg::PH_HEADER && hcount_next != '0) begin
          result.status = tlvts_pkg::ST_TRUNC;
        end else begin
          result.status = tlvts_pkg::ST_NOT_FOUND;
        end
        // rearm for the next buffer
        pos_next       = '0;
        phase_next     = tlvts_pkg::PH_SKIP;
        hcount_next    = '0;
        hshift_next    = '0;
        remaining_next = '0;
        found_next     = 1'b0;
        mpos_next      = '0;
        mlen_next      = '0;
        acc_next       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      phase     <= tlvts_pkg::PH_SKIP;
      hcount    <= '0;
      hshift    <= '0;
      remaining <= '0;
      found     <= 1'b0;
      mpos      <= '0;
      mlen      <= '0;
      acc       <= '0;
    end else begin
      pos       <= pos_next;
      phase     <= phase_next;
      hcount    <= hcount_next;
      hshift    <= hshift_next;
      remaining <= remaining_next;
      found     <= found_next;
      mpos      <= mpos_next;
      mlen      <= mlen_next;
      acc       <= acc_next;
    end
  end

endmodule

### hdl/tlv_tag_search.sv
// TLV tag search. Takes one buffer byte per word on the slave side, with tlast on the final
// byte, and returns one result word per buffer on the master side. The last byte passes the input
// register into the core, and the output register then captures its result once any earlier result has
// been taken. Throughput is one byte per cycle: each byte updates
// a small parse state (header shift, value countdown, value accumulator) in a single pass, and
// an input register and an output register decouple the two sides, so the input stalls only
// when a new result would overwrite one not yet taken. Configuration is written through
// cfg_we/cfg_index/cfg_data while no buffer is in flight. Header fields are byte-swapped when
// header_big_endian is 0. The position counter stops at 65535; bytes at that position and beyond are ignored but
// tlast still closes the buffer.
module tlv_tag_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tlvts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlvts_pkg::CFG_DW-1:0]     cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // data_byte
  input  logic                             s_tlast,   // last_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [63:0]                      m_tdata,   // match_offset[15:0], value_length[31:16], value[63:32]
  output logic [1:0]                       m_tuser    // status
);

  tlvts_pkg::cfg_t    cfg;
  tlvts_pkg::result_t res, res_q;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tlvts_pkg::REG_SEARCH_TAG:   cfg.search_tag <= cfg_data;
        tlvts_pkg::REG_START_OFFSET: cfg.start_offset <= cfg_data[tlvts_pkg::POS_W-1:0];
        tlvts_pkg::REG_HDR_BIG_END:  cfg.header_big_endian <= cfg_data[0];
        tlvts_pkg::REG_RESULT_WIDTH: cfg.result_width <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // hold the last byte while the previous result is still waiting
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  tlvts_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res_q.status;
  assign m_tdata  = {res_q.value, res_q.value_length, res_q.match_offset};

endmodule

### dv/tlv_tag_search_tb.sv
`timescale 1ns / 100ps

module tlv_tag_search_tb;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  // width code three is not in the enum; the block treats it as uint8
  localparam logic [1:0] WIDTH_CODE3 = 2'd3;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = tlvts_pkg::REG_SEARCH_TAG;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // data_byte
  logic        s_tlast = 1'b0; // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // match_offset[15:0], value_length[31:16], value[63:32]
  logic [1:0]  m_tuser;        // status

  tlv_tag_search DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // register copies
  logic [31:0] tag_cfg;
  logic [15:0] start_cfg;
  logic        big_cfg;
  logic [1:0]  width_cfg;

  // scan state
  logic [15:0]       at_pos;
  tlvts_pkg::phase_t phase;
  logic [2:0]        hdr_n;
  logic [47:0]       hdr_sr;
  logic [15:0]       val_left;
  logic              hit;
  logic [15:0]       hit_pos;
  logic [15:0]       hit_len;
  logic [31:0]       val_acc;

  in_word_t           byte_q[$];
  logic [7:0]         frame_q[$];
  tlvts_pkg::result_t search_results[$];

  int unsigned words_sent = 0;
  int unsigned bad_count = 0;
  int unsigned cycles = 0;
  logic        word_taken = 1'b0;
  logic        hold_long = 1'b0;

  function automatic void rearm_scan();
    at_pos   = '0;
    phase    = tlvts_pkg::PH_SKIP;
    hdr_n    = '0;
    hdr_sr   = '0;
    val_left = '0;
    hit      = 1'b0;
    hit_pos  = '0;
    hit_len  = '0;
    val_acc  = '0;
  endfunction

  function automatic logic len_fits(input logic [15:0] len);
    case (width_cfg)
      tlvts_pkg::WIDTH_U32: return (len == 16'd4) || (len == 16'd2) || (len == 16'd1);
      tlvts_pkg::WIDTH_U16: return (len == 16'd2) || (len == 16'd1);
      default:              return (len == 16'd1);
    endcase
  endfunction

  // advance the scan by one byte; on the last byte queue the buffer's result and rearm
  task automatic scan_byte(input logic [7:0] b, input logic last);
    tlvts_pkg::result_t r;
    logic [31:0]        tag;
    logic [15:0]        len;
    if (at_pos != tlvts_pkg::POS_MAX) begin
      if (phase == tlvts_pkg::PH_SKIP && at_pos == start_cfg) phase = tlvts_pkg::PH_HEADER;
      if (phase == tlvts_pkg::PH_HEADER) begin
        hdr_sr = {hdr_sr[39:0], b};
        hdr_n  = hdr_n + 3'd1;
        if (hdr_n == 3'(tlvts_pkg::HDR_BYTES)) begin
          tag = hdr_sr[47:16];
          len = hdr_sr[15:0];
          if (!big_cfg) begin
            tag = {tag[7:0], tag[15:8], tag[23:16], tag[31:24]};
            len = {len[7:0], len[15:8]};
          end
          hdr_n    = '0;
          hdr_sr   = '0;
          val_left = len;
          if (tag == tag_cfg) begin
            hit     = 1'b1;
            hit_pos = at_pos - tlvts_pkg::HDR_BACK;
            hit_len = len;
            val_acc = '0;
            phase   = (len == 16'd0) ? tlvts_pkg::PH_DONE : tlvts_pkg::PH_VALUE;
          end else begin
            phase   = (len == 16'd0) ? tlvts_pkg::PH_HEADER : tlvts_pkg::PH_VALUE;
          end
        end
      end else if (phase == tlvts_pkg::PH_VALUE) begin
        if (hit && hit_len <= 16'd4) val_acc = {val_acc[23:0], b};
        val_left = val_left - 16'd1;
        if (val_left == 16'd0) phase = hit ? tlvts_pkg::PH_DONE : tlvts_pkg::PH_HEADER;
      end
      at_pos = at_pos + 16'd1;
    end
    if (last) begin
      r.status       = tlvts_pkg::ST_NOT_FOUND;
      r.match_offset = '0;
      r.value_length = '0;
      r.value        = '0;
      if (hit) begin
        r.match_offset = hit_pos;
        r.value_length = hit_len;
        if (!len_fits(hit_len)) r.status = tlvts_pkg::ST_BAD_LEN;
        else if (phase != tlvts_pkg::PH_DONE) r.status = tlvts_pkg::ST_TRUNC;
        else begin
          r.status = tlvts_pkg::ST_FOUND;
          r.value  = val_acc;
        end
      end else if (phase == tlvts_pkg::PH_HEADER && hdr_n != 3'd0) begin
        r.status = tlvts_pkg::ST_TRUNC;
      end
      search_results.push_back(r);
      rearm_scan();
    end
  endtask

  // sample both sides, predict accepted bytes, check returned words
  always @(posedge clk) begin : monitor
    tlvts_pkg::result_t got;
    tlvts_pkg::result_t want;
    word_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        word_taken = 1'b1;
        scan_byte(s_tdata, s_tlast);
        void'(byte_q.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got.status       = tlvts_pkg::status_t'(m_tuser);
        got.match_offset = m_tdata[15:0];
        got.value_length = m_tdata[31:16];
        got.value        = m_tdata[63:32];
        if (search_results.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: result word with nothing pending: status %0d off %0d len %0d val %h",
                     $realtime, got.status, got.match_offset, got.value_length,
                     got.value);
        end else begin
          want = search_results.pop_front();
          if (got.status != want.status || got.match_offset != want.match_offset ||
              got.value_length != want.value_length || got.value != want.value) begin
            bad_count++;
            if (bad_count <= 10)
              $display({"%0t: mismatch: exp status %0d off %0d len %0d val %h, ",
                        "got status %0d off %0d len %0d val %h"},
                       $realtime, want.status, want.match_offset, want.value_length,
                       want.value, got.status, got.match_offset, got.value_length,
                       got.value);
          end
        end
      end
    end
  end

  // sender: bursts of random length with random gaps; hold a word until taken
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (!s_tvalid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= byte_q[0].data;
        s_tlast  <= byte_q[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  int unsigned stall_left = 0;
  int unsigned mode_left = 0;
  logic        hold_seen = 1'b0;
  rx_mode_t    rx_mode = RX_OPEN;

  always @(negedge clk) begin
    if (hold_long && !hold_seen) begin
      hold_seen  = 1'b1;
      stall_left = 80;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN: m_tready <= 1'b1;
        RX_COIN: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      tlvts_pkg::REG_SEARCH_TAG:   tag_cfg = val;
      tlvts_pkg::REG_START_OFFSET: start_cfg = val[15:0];
      tlvts_pkg::REG_HDR_BIG_END:  big_cfg = val[0];
      default:                     width_cfg = val[1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] tag, input logic [15:0] start,
                            input logic big, input logic [1:0] width);
    write_reg(tlvts_pkg::REG_SEARCH_TAG, tag);
    write_reg(tlvts_pkg::REG_START_OFFSET, 32'(start));
    write_reg(tlvts_pkg::REG_HDR_BIG_END, 32'(big));
    write_reg(tlvts_pkg::REG_RESULT_WIDTH, 32'(width));
  endtask

  // wait until every byte is taken and every result has come back
  task automatic drain();
    while (byte_q.size() != 0 || s_tvalid || search_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_header(input logic [31:0] tag, input logic [15:0] len);
    for (int k = 0; k < 4; k++)
      frame_q.push_back(big_cfg ? tag[8*(3-k) +: 8] : tag[8*k +: 8]);
    for (int k = 0; k < 2; k++)
      frame_q.push_back(big_cfg ? len[8*(1-k) +: 8] : len[8*k +: 8]);
  endtask

  task automatic send_buffer();
    in_word_t w;
    foreach (frame_q[i]) begin
      w.data = frame_q[i];
      w.last = (i == frame_q.size() - 1);
      byte_q.push_back(w);
    end
    words_sent += frame_q.size();
    frame_q.delete();
  endtask

  // mostly well-formed record chains with random content; some cut short or padded
  task automatic rand_buffer();
    int unsigned lead;
    int unsigned len;
    int unsigned keep;
    logic [31:0] tag;
    lead = (start_cfg > 16) ? $urandom_range(1, 20) : start_cfg;
    repeat (lead) frame_q.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0, 1:    tag = tag_cfg;
        2:       tag = tag_cfg ^ (32'h1 << $urandom_range(0, 31));
        default: tag = $urandom;
      endcase
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      put_header(tag, len[15:0]);
      repeat (len) frame_q.push_back(8'($urandom));
    end
    if (frame_q.size() == 0) frame_q.push_back(8'($urandom));
    case ($urandom_range(0, 3))
      0: begin
        keep = $urandom_range(1, frame_q.size());
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      1: repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
      default: ;
    endcase
    send_buffer();
  endtask

  task automatic random_scan(input int unsigned target);
    int unsigned stop;
    stop = words_sent + target;
    while (words_sent < stop) begin
      rand_buffer();
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  initial begin
    tag_cfg   = '0;
    start_cfg = '0;
    big_cfg   = 1'b0;
    width_cfg = tlvts_pkg::WIDTH_U32;
    rearm_scan();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset settings: tag 0, offset 0, little-endian header, uint32
    frame_q.push_back(8'hFF);                // end inside a header
    send_buffer();
    put_header(32'h0, 16'd4);                // full uint32 match
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h80);
    send_buffer();
    put_header(32'h0, 16'd0);                // zero-length match
    send_buffer();
    put_header(32'h1234_5678, 16'd3);        // end inside a non-matching value
    frame_q.push_back(8'h00);
    send_buffer();
    drain();

    set_config($urandom, 16'd0, 1'b1, tlvts_pkg::WIDTH_U32);
    random_scan(120);
    drain();
    set_config(32'hFFFF_FFFF, 16'd3, 1'b0, tlvts_pkg::WIDTH_U16);
    random_scan(120);
    drain();
    set_config($urandom, 16'd7, 1'b1, tlvts_pkg::WIDTH_U8);
    random_scan(120);
    drain();
    set_config($urandom, 16'd1, 1'b0, WIDTH_CODE3);
    random_scan(120);
    drain();

    // short buffers against a long output stall so the input backs up
    set_config(32'h0, 16'd0, 1'b1, tlvts_pkg::WIDTH_U32);
    hold_long = 1'b1;
    repeat (30) begin
      repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      send_buffer();
    end
    random_scan(120);
    drain();

    // start offset never reached
    set_config($urandom, 16'hFFFF, 1'b0, tlvts_pkg::WIDTH_U32);
    random_scan(40);
    drain();

    repeat (10) @(negedge clk);
    if (bad_count == 0 && search_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
